FILE: rtl/scr_pkg.sv
// Shared constants, types and helpers for the sphere collision response pipeline.
`default_nettype none

package scr_pkg;

  localparam int CW            = 32;          // coordinate and force width
  localparam int DXW           = CW + 1;      // offset from center
  localparam int RW            = 31;          // radius width
  localparam int ROOT_W        = 31;          // distance (square root) width
  localparam int D2_W          = 2 * RW;      // squared distance inside the sphere
  localparam int NUM_W         = D2_W + 1;    // divider numerator
  localparam int CFG_IDX_W     = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd3;

  localparam logic [RW-1:0] RADIUS_RESET = 31'd65536;

  typedef logic [2:0][CW-1:0] vec3_t;

  typedef struct packed {
    vec3_t      pos;
    vec3_t      frc;
    vec3_t      org;
    logic       self_sphere;
    logic       hit;
    logic       zero;
    logic [2:0] dneg;
  } node_info_t;

  typedef struct packed {
    node_info_t           info;
    logic [2:0][RW-1:0]   mag;
    logic [2:0][D2_W-1:0] prod;
  } sqrt_side_t;

  function automatic logic [CW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[CW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/scr_if.sv
// Channel interfaces: node input, result output and configuration writes.
`default_nettype none

interface scr_node_if import scr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic signed [CW-1:0] force_x;
  logic signed [CW-1:0] force_y;
  logic signed [CW-1:0] force_z;
  logic signed [CW-1:0] orig_force_x;
  logic signed [CW-1:0] orig_force_y;
  logic signed [CW-1:0] orig_force_z;
  logic              self_sphere;

  modport source (output valid, pos_x, pos_y, pos_z, force_x, force_y, force_z,
                  orig_force_x, orig_force_y, orig_force_z, self_sphere,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, force_x, force_y, force_z,
                orig_force_x, orig_force_y, orig_force_z, self_sphere,
                output ready);
endinterface

interface scr_result_if import scr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] new_pos_x;
  logic signed [CW-1:0] new_pos_y;
  logic signed [CW-1:0] new_pos_z;
  logic signed [CW-1:0] new_force_x;
  logic signed [CW-1:0] new_force_y;
  logic signed [CW-1:0] new_force_z;
  logic              hit;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_force_x,
                  new_force_y, new_force_z, hit, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_force_x,
                new_force_y, new_force_z, hit, output ready);
endinterface

interface scr_cfg_if import scr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/scr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module scr_sqrt import scr_pkg::*; (
  input  wire              clk,
  input  wire              en,
  input  wire [D2_W-1:0]   v,
  output logic [ROOT_W-1:0] root
);

  logic [D2_W-1:0]   rem [ROOT_W-1];
  logic [ROOT_W-1:0] rt  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam int K = ROOT_W - 1 - j;
    logic [D2_W-1:0]   rem_in;
    logic [ROOT_W-1:0] rt_in;
    logic [D2_W+1:0]   trial;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in = v;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign rt_in  = rt[j-1];
    end

    // (root + 2^K)^2 - root^2
    assign trial = ((D2_W+2)'(rt_in) << (K + 1)) + ((D2_W+2)'(1) << (2 * K));
    assign take  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt[j] <= take ? (rt_in | (ROOT_W'(1) << K)) : rt_in;
      end
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= take ? (rem_in - trial[D2_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/scr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module scr_div import scr_pkg::*; (
  input  wire               clk,
  input  wire               en,
  input  wire [NUM_W-1:0]   num,
  input  wire [ROOT_W-1:0]  den,
  output logic [ROOT_W-1:0] quo
);

  logic [NUM_W-1:0]  rem   [ROOT_W-1];
  logic [ROOT_W-1:0] den_q [ROOT_W-1];
  logic [ROOT_W-1:0] q     [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam int K = ROOT_W - 1 - j;
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [ROOT_W-1:0] q_in;
    logic [NUM_W:0]    dsh;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign den_in = den_q[j-1];
      assign q_in   = q[j-1];
    end

    assign dsh  = (NUM_W+1)'(den_in) << K;
    assign take = {1'b0, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q[j] <= take ? (q_in | (ROOT_W'(1) << K)) : q_in;
      end
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j]   <= take ? (rem_in - dsh[NUM_W-1:0]) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo = q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/sphere_collision_response.sv
// Top level: sphere collision response pipeline for cloth nodes.
`default_nettype none

// Pushes cloth nodes that lie inside a configured sphere out onto its surface and
// cuts their force to the tangential part; a self-sphere node or one at the exact
// center keeps its force, and on a miss other nodes get the original force back.
// One node is taken every cycle while the output is not stalled. The pipeline has 71
// register stages: three for the offset, squares and hit test, the 31-stage square
// root, one for the rounded numerators, the 31-stage divider and five for the force
// math and the result register. The whole pipeline holds while a finished result is
// not taken, so input transfers stop only when the output stage is full and stalled.
// Center and radius registers are written through the configuration channel; the
// user must write them only while no node is in flight, which the block does not
// enforce. Writes to indexes past the radius are ignored.
module sphere_collision_response import scr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire           clk,
  input wire           rst,
  scr_cfg_if.sink      cfg,
  scr_node_if.sink     node,
  scr_result_if.source result
);

  localparam int UW  = FRAC_BITS + 2;       // signed unit normal
  localparam int FW  = CW + UW;             // force * normal
  localparam int DW  = FW + 2;              // dot product
  localparam int SW  = 35;                  // normal force component
  localparam int SUW = SW + UW;
  localparam int TW  = SUW - FRAC_BITS;
  localparam int N_STAGES = 3 + ROOT_W + 1 + ROOT_W + 5;

  // ---------------- configuration ----------------
  logic [CW-1:0] center_x, center_y, center_z;
  logic [RW-1:0] radius;
  vec3_t         ctr;

  assign cfg.ready = 1'b1;
  assign ctr = {center_z, center_y, center_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= RADIUS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: center_x <= cfg.data;
        REG_CENTER_Y: center_y <= cfg.data;
        REG_CENTER_Z: center_z <= cfg.data;
        REG_RADIUS:   radius   <= cfg.data[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic                en;
  logic [N_STAGES-1:0] vld;

  assign en         = !vld[N_STAGES-1] || result.ready;
  assign node.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_STAGES-2:0], node.valid};
    end
  end

  // ---------------- stage 1: offset from center ----------------
  vec3_t                 in_pos, in_frc, in_org;
  logic signed [DXW-1:0] d    [3];
  logic [DXW-1:0]        dmag [3];
  logic [2:0]            lt;

  assign in_pos = {node.pos_z, node.pos_y, node.pos_x};
  assign in_frc = {node.force_z, node.force_y, node.force_x};
  assign in_org = {node.orig_force_z, node.orig_force_y, node.orig_force_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]    = $signed({in_pos[i][CW-1], in_pos[i]}) - $signed({ctr[i][CW-1], ctr[i]});
      dmag[i] = d[i][DXW-1] ? DXW'(-d[i]) : DXW'(d[i]);
      lt[i]   = dmag[i] < DXW'(radius);
    end
  end

  node_info_t         s1_info;
  logic [2:0][RW-1:0] s1_mag;
  logic               s1_all_lt;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_info.pos         <= in_pos;
      s1_info.frc         <= in_frc;
      s1_info.org         <= in_org;
      s1_info.self_sphere <= node.self_sphere;
      s1_info.hit         <= 1'b0;
      s1_info.zero        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        s1_info.dneg[i] <= d[i][DXW-1];
        s1_mag[i]       <= dmag[i][RW-1:0];
      end
      s1_all_lt <= &lt;
    end
  end

  // ---------------- stage 2: squares and products ----------------
  node_info_t           s2_info;
  logic [2:0][RW-1:0]   s2_mag;
  logic [2:0][D2_W-1:0] s2_sq;
  logic [2:0][D2_W-1:0] s2_pr;
  logic [D2_W-1:0]      s2_rr;
  logic                 s2_all_lt;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_info   <= s1_info;
      s2_mag    <= s1_mag;
      s2_all_lt <= s1_all_lt;
      s2_rr     <= radius * radius;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= s1_mag[i] * s1_mag[i];
        s2_pr[i] <= s1_mag[i] * radius;
      end
    end
  end

  // ---------------- stage 3: squared distance and hit test ----------------
  logic [D2_W+1:0] d2sum;
  logic            s3_hit_c;
  node_info_t      s3_info_c;
  sqrt_side_t      s3_side;
  logic [D2_W-1:0] s3_d2;

  assign d2sum    = (D2_W+2)'(s2_sq[0]) + (D2_W+2)'(s2_sq[1]) + (D2_W+2)'(s2_sq[2]);
  assign s3_hit_c = s2_all_lt && (d2sum < (D2_W+2)'(s2_rr));

  always_comb begin
    s3_info_c      = s2_info;
    s3_info_c.hit  = s3_hit_c;
    s3_info_c.zero = d2sum == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side.info <= s3_info_c;
      s3_side.mag  <= s2_mag;
      s3_side.prod <= s2_pr;
      s3_d2        <= s3_hit_c ? d2sum[D2_W-1:0] : '0;
    end
  end

  // ---------------- square root ----------------
  logic [ROOT_W-1:0] root;
  sqrt_side_t        side_a [ROOT_W];

  scr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (s3_d2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_a[0] <= s3_side;
      for (int j = 1; j < ROOT_W; j++) begin
        side_a[j] <= side_a[j-1];
      end
    end
  end

  // ---------------- stage 4: rounded numerators ----------------
  sqrt_side_t        sa;
  node_info_t        s4_info;
  logic [ROOT_W-1:0] s4_den;
  logic [NUM_W-1:0]  s4_nump [3];
  logic [NUM_W-1:0]  s4_numu [3];

  assign sa = side_a[ROOT_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_info <= sa.info;
      s4_den  <= root;
      for (int i = 0; i < 3; i++) begin
        s4_nump[i] <= NUM_W'(sa.prod[i]) + NUM_W'(root >> 1);
        s4_numu[i] <= (NUM_W'(sa.mag[i]) << FRAC_BITS) + NUM_W'(root >> 1);
      end
    end
  end

  // ---------------- dividers ----------------
  logic [ROOT_W-1:0] qp [3];
  logic [ROOT_W-1:0] qu [3];
  node_info_t        side_b [ROOT_W];

  for (genvar i = 0; i < 3; i++) begin : g_div
    scr_div u_div_pos (
      .clk (clk),
      .en  (en),
      .num (s4_nump[i]),
      .den (s4_den),
      .quo (qp[i])
    );
    scr_div u_div_nrm (
      .clk (clk),
      .en  (en),
      .num (s4_numu[i]),
      .den (s4_den),
      .quo (qu[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b[0] <= s4_info;
      for (int j = 1; j < ROOT_W; j++) begin
        side_b[j] <= side_b[j-1];
      end
    end
  end

  // ---------------- post 1: signed normal, new position ----------------
  node_info_t             sb;
  logic signed [CW+1:0]   pq   [3];
  logic signed [CW+1:0]   psum [3];
  logic signed [UW-1:0]   u_c  [3];
  node_info_t             p1_info;
  logic signed [UW-1:0]   p1_u [3];
  vec3_t                  p1_pos;

  assign sb = side_b[ROOT_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pq[i]   = sb.dneg[i] ? -$signed({3'b000, qp[i]}) : $signed({3'b000, qp[i]});
      psum[i] = $signed({{2{ctr[i][CW-1]}}, ctr[i]}) + pq[i];
      u_c[i]  = sb.dneg[i] ? -$signed(UW'(qu[i])) : $signed(UW'(qu[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_info <= sb;
      for (int i = 0; i < 3; i++) begin
        p1_u[i]   <= u_c[i];
        // a node at the exact center stays where it is
        p1_pos[i] <= (sb.hit && !sb.zero) ? sat32(64'(psum[i])) : sb.pos[i];
      end
    end
  end

  // ---------------- post 2: force times normal ----------------
  node_info_t           p2_info;
  logic signed [UW-1:0] p2_u  [3];
  logic signed [FW-1:0] p2_fu [3];
  vec3_t                p2_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_info <= p1_info;
      p2_pos  <= p1_pos;
      for (int i = 0; i < 3; i++) begin
        p2_u[i]  <= p1_u[i];
        p2_fu[i] <= $signed(p1_info.frc[i]) * p1_u[i];
      end
    end
  end

  // ---------------- post 3: dot product, rounded ----------------
  logic signed [DW-1:0] dot;
  logic [DW-1:0]        dot_mag, dot_q;
  logic signed [SW-1:0] s_c;
  node_info_t           p3_info;
  logic signed [UW-1:0] p3_u [3];
  logic signed [SW-1:0] p3_s;
  vec3_t                p3_pos;

  always_comb begin
    dot     = DW'(p2_fu[0]) + DW'(p2_fu[1]) + DW'(p2_fu[2]);
    dot_mag = dot[DW-1] ? DW'(-dot) : DW'(dot);
    dot_q   = (dot_mag + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    s_c     = dot[DW-1] ? -$signed(SW'(dot_q)) : $signed(SW'(dot_q));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_info <= p2_info;
      p3_pos  <= p2_pos;
      p3_s    <= s_c;
      for (int i = 0; i < 3; i++) begin
        p3_u[i] <= p2_u[i];
      end
    end
  end

  // ---------------- post 4: normal component ----------------
  node_info_t            p4_info;
  logic signed [SUW-1:0] p4_su [3];
  vec3_t                 p4_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_info <= p3_info;
      p4_pos  <= p3_pos;
      for (int i = 0; i < 3; i++) begin
        p4_su[i] <= p3_s * p3_u[i];
      end
    end
  end

  // ---------------- post 5: tangential force, result register ----------------
  logic [SUW-1:0]       t_mag [3];
  logic [SUW-1:0]       t_q   [3];
  logic signed [TW-1:0] t     [3];
  logic signed [TW:0]   nf    [3];
  vec3_t                frc_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_mag[i] = p4_su[i][SUW-1] ? SUW'(-p4_su[i]) : SUW'(p4_su[i]);
      t_q[i]   = (t_mag[i] + (SUW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      t[i]     = p4_su[i][SUW-1] ? -$signed(TW'(t_q[i])) : $signed(TW'(t_q[i]));
      nf[i]    = (TW+1)'($signed(p4_info.frc[i])) - (TW+1)'(t[i]);
      if (!p4_info.hit) begin
        frc_c[i] = p4_info.self_sphere ? p4_info.frc[i] : p4_info.org[i];
      end else if (p4_info.self_sphere || p4_info.zero) begin
        frc_c[i] = p4_info.frc[i];
      end else begin
        frc_c[i] = sat32(64'(nf[i]));
      end
    end
  end

  vec3_t res_pos, res_frc;
  logic  res_hit;

  always_ff @(posedge clk) begin
    if (en) begin
      res_pos <= p4_pos;
      res_frc <= frc_c;
      res_hit <= p4_info.hit;
    end
  end

  assign result.valid       = vld[N_STAGES-1];
  assign result.new_pos_x   = res_pos[0];
  assign result.new_pos_y   = res_pos[1];
  assign result.new_pos_z   = res_pos[2];
  assign result.new_force_x = res_frc[0];
  assign result.new_force_y = res_frc[1];
  assign result.new_force_z = res_frc[2];
  assign result.hit         = res_hit;

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    node.ready == (!result.valid || result.ready))
    else $error("input ready does not follow output stall");

  a_out_of_box_miss: assert property (@(posedge clk) disable iff (rst)
    en && vld[1] && !s2_all_lt |=> !s3_side.info.hit)
    else $error("hit flagged for node outside bounding box");

  a_center_hit: assert property (@(posedge clk) disable iff (rst)
    en && vld[1] && s2_all_lt && (d2sum == '0) |=> s3_side.info.hit)
    else $error("node at center not flagged as hit");

  a_miss_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    en && vld[N_STAGES-2] && !p4_info.hit |=> result.new_pos_x == $past(p4_pos[0]))
    else $error("missed node position changed");
`endif

endmodule

`default_nettype wire
